// File: rtl/sorted_table_binary_search_macros.svh
// Assertion macros for the verification of the sorted table.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/stsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stsb_pkg;

    // Default table depth.
    localparam int STSB_MAX_ENTRIES = 128;

    // Command kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Command word.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic       found;
        logic [7:0] position;
        logic [3:0] probe_count;
    } res_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               ins;
        logic               clr;
        logic signed [31:0] operand;
    } cell_cmd_t;

    // What each cell hands to its right-hand neighbour.
    typedef struct packed {
        logic               vld;
        logic               gt;
        logic signed [31:0] val;
    } cell_link_t;

endpackage
`default_nettype wire

// File: rtl/stsb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module stsb_cell
    import stsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_cmd_t  cmd,
    input  wire cell_link_t left,
    output cell_link_t      right,
    output logic            eq
);

    logic signed [31:0] entry_reg;
    logic               vld_reg;
    logic               gt;
    logic               slot;
    logic               wr;
    logic signed [31:0] entry_next;

    // Compare the held entry with the broadcast operand.
    assign gt = vld_reg && (entry_reg > cmd.operand);
    assign eq = vld_reg && (entry_reg == cmd.operand);

    // The first empty cell takes part in an insertion as the new top slot.
    assign slot       = !vld_reg && left.vld;
    assign wr         = cmd.ins && (gt || slot);
    assign entry_next = left.gt ? left.val : cmd.operand;

    // Entry storage, shifted up one place when a smaller value arrives.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg <= entry_next;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (cmd.clr)
        begin
            vld_reg <= 1'b0;
        end
        else if (wr)
        begin
            vld_reg <= 1'b1;
        end
    end

    assign right = '{vld: vld_reg, gt: gt, val: entry_reg};

endmodule
`default_nettype wire

// File: rtl/sorted_table_binary_search.sv
// Clear: taken at acceptance. Load: every cell shifts in parallel in the load state.
// Search: one probe per cycle, at most ceil(log2(MAX_ENTRIES + 1)) probes, then a
// result state that waits until the result register is free.
// One word is in work at a time; the result register frees the block to take the next.
// Reset empties the table, clears state, count and res_valid; entries are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_binary_search
    import stsb_pkg::*;
#(
    parameter int MAX_ENTRIES = STSB_MAX_ENTRIES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] operand_reg;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [3:0]         probes_reg, probes_next;
    logic               hit_reg, hit_next;
    logic [CW-1:0]      where_reg, where_next;
    logic               res_valid_reg;
    res_t               res_reg;

    logic               accept;
    logic               full;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic [IW-1:0]      mid_idx;
    logic               slot_free;
    cell_cmd_t          cell_cmd;
    cell_link_t         links [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] eq_vec;
    logic [MAX_ENTRIES-1:0] gt_vec;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign full      = (count_reg == CW'(MAX_ENTRIES));
    assign slot_free = !res_valid_reg || res_ready;

    // Probe address: floor((lo + hi - 1) / 2), only used while lo < hi.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[CW:1];
    assign mid_idx = mid[IW-1:0];

    // Broadcast to the row of cells.
    assign cell_cmd.ins     = (state_reg == ST_LOAD) && !full;
    assign cell_cmd.clr     = accept && (cmd.kind == KIND_CLEAR);
    assign cell_cmd.operand = operand_reg;

    assign links[0] = '{vld: 1'b1, gt: 1'b0, val: '0};

    // Row of entry cells.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        stsb_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cell_cmd),
            .left  (links[i]),
            .right (links[i+1]),
            .eq    (eq_vec[i])
        );
        assign gt_vec[i] = links[i+1].gt;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        probes_next = probes_reg;
        hit_next    = hit_reg;
        where_next  = where_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_LOAD:
                        begin
                            state_next = ST_LOAD;
                        end
                        KIND_SEARCH:
                        begin
                            state_next  = ST_SEARCH;
                            lo_next     = '0;
                            hi_next     = count_reg;
                            probes_next = '0;
                            hit_next    = 1'b0;
                            where_next  = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (!full)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    probes_next = probes_reg + 4'd1;
                    if (eq_vec[mid_idx])
                    begin
                        hit_next   = 1'b1;
                        where_next = mid + CW'(1);
                        state_next = ST_RESULT;
                    end
                    else if (gt_vec[mid_idx])
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + CW'(1);
                    end
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == ST_RESULT) && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Operand and search registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            operand_reg <= cmd.value;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        probes_reg <= probes_next;
        hit_reg    <= hit_next;
        where_reg  <= where_next;
        if ((state_reg == ST_RESULT) && slot_free)
        begin
            res_reg.found       <= hit_reg;
            res_reg.position    <= 8'(where_reg);
            res_reg.probe_count <= probes_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// File: rtl/stsb_props.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_binary_search_macros.svh"
module stsb_props
    import stsb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire cmd_t cmd,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res
);

    // A result word waits until it is taken.
    `STSB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped")

    // A hit carries a real position and at least one probe.
    `STSB_ASSERT_NOW(a_hit_pos, res_valid && res.found, res.position != 8'd0 && res.probe_count != 4'd0, "hit without position or probe")

    // A miss reports position zero.
    `STSB_ASSERT_NOW(a_miss_pos, res_valid && !res.found, res.position == 8'd0, "miss with non-zero position")

    // The block is busy in the cycle after it takes a search word.
    `STSB_ASSERT_NEXT(a_search_busy, cmd_valid && cmd_ready && cmd.kind == KIND_SEARCH, !cmd_ready, "search word did not occupy the block")

endmodule

bind sorted_table_binary_search stsb_props u_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
`default_nettype wire

// File: tb/sv/tb_sorted_table_binary_search.sv
`timescale 1ns / 1ps
module tb_sorted_table_binary_search;
    import stsb_pkg::*;

    // The fourth command code has no meaning and must be ignored.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 60;

    // Tracks the sorted table and the search results it should produce.
    class search_scoreboard;
        logic signed [31:0] entries [STSB_MAX_ENTRIES];
        int unsigned        fill;
        res_t               pending_results [$];
        int unsigned        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Binary search over the filled entries, as the block should run it.
        function res_t search_outcome(logic signed [31:0] key);
            res_t r;
            int   lo;
            int   hi;
            int   mid;
            int   probes;
            r      = '0;
            lo     = 0;
            hi     = fill;
            probes = 0;
            while (lo < hi) begin
                mid = (lo + hi - 1) / 2;
                probes++;
                if (key == entries[mid]) begin
                    r.found    = 1'b1;
                    r.position = 8'(mid + 1);
                    break;
                end
                else if (key < entries[mid]) begin
                    hi = mid;
                end
                else begin
                    lo = mid + 1;
                end
            end
            r.probe_count = 4'(probes);
            return r;
        endfunction

        // Updates the table for an accepted command word.
        function void note_word(cmd_t w);
            logic signed [31:0] v;
            int                 pos;
            v = w.value;
            case (w.kind)
                KIND_CLEAR:
                begin
                    fill = 0;
                end
                KIND_LOAD:
                begin
                    // A load into a full table is dropped.
                    if (fill < STSB_MAX_ENTRIES) begin
                        pos = fill;
                        while (pos > 0 && entries[pos - 1] > v) begin
                            entries[pos] = entries[pos - 1];
                            pos--;
                        end
                        entries[pos] = v;
                        fill++;
                    end
                end
                KIND_SEARCH:
                begin
                    pending_results.push_back(search_outcome(v));
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compares an accepted result word with the oldest expectation.
        function void check_result(res_t got);
            res_t exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word found=%0d position=%0d probes=%0d",
                         $time, got.found, got.position, got.probe_count);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.found !== exp_r.found) begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, exp_r.found, got.found);
                errors++;
            end
            if (got.position !== exp_r.position) begin
                $display("%0t: position mismatch, expected %0d, actual %0d",
                         $time, exp_r.position, got.position);
                errors++;
            end
            if (got.probe_count !== exp_r.probe_count) begin
                $display("%0t: probe_count mismatch, expected %0d, actual %0d",
                         $time, exp_r.probe_count, got.probe_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    search_scoreboard sb;
    int               burst_left;
    int               idle_cycles;

    sorted_table_binary_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watch both channels and score every word that crosses them.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready) begin
                sb.note_word(cmd);
            end
            if (res_valid && res_ready) begin
                sb.check_result(res);
            end
        end
    end

    // Give up when no word has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_table_binary_search test failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The result side stalls in segments: always ready, coin toss, or mostly stalled.
    initial
    begin : result_stalls
        int seg_left;
        int seg_mode;
        seg_left = 0;
        seg_mode = 0;
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (seg_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                default: res_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Sends one command word, with a random gap at the start of each burst.
    task automatic send_item(input logic [1:0] kind, input logic signed [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= '{kind: kind, value: value};
        do @(posedge clk); while (!cmd_ready);
    endtask

    // Holds the command side off until every search has answered.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // Value for a load, by the style chosen for the current phase.
    function automatic logic signed [31:0] load_value(int style);
        case (style)
            0: return 32'($signed($urandom_range(0, 16)) - 8);
            1: return 32'($urandom());
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return 32'($urandom());
                    default: return 32'($signed($urandom_range(0, 6)) - 3);
                endcase
            end
        endcase
    endfunction

    // Search key: mostly stored entries, then their neighbours, extremes and noise.
    function automatic logic signed [31:0] search_key();
        int sel;
        logic signed [31:0] base;
        sel = $urandom_range(0, 9);
        if (sb.fill != 0 && sel <= 7) begin
            base = sb.entries[$urandom_range(0, sb.fill - 1)];
            if (sel == 6) return base + 32'sd1;
            if (sel == 7) return base - 32'sd1;
            return base;
        end
        if (sel == 8) return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
        return 32'($urandom());
    endfunction

    // Main sequence.
    initial
    begin : stimulus
        int items;
        int phase_no;
        int n_loads;
        int n_searches;
        int style;

        sb          = new();
        burst_left  = 0;
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        cmd        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extremes, duplicates, misses and ignored codes.
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_UNUSED, VAL_MAX);
        send_item(KIND_LOAD, 32'sd0);
        send_item(KIND_LOAD, VAL_MIN);
        send_item(KIND_LOAD, VAL_MAX);
        send_item(KIND_LOAD, -32'sd1);
        send_item(KIND_LOAD, 32'sd0);
        send_item(KIND_LOAD, 32'sd1);
        send_item(KIND_SEARCH, VAL_MIN);
        send_item(KIND_SEARCH, VAL_MAX);
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_SEARCH, -32'sd1);
        send_item(KIND_SEARCH, 32'sd2);
        send_item(KIND_SEARCH, VAL_MIN + 32'sd1);
        send_item(KIND_UNUSED, 32'sh5A5A_A5A5);
        send_item(KIND_SEARCH, 32'sd1);
        send_item(KIND_CLEAR, 32'sd0);
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_LOAD, 32'sd5);
        send_item(KIND_SEARCH, 32'sd5);
        send_item(KIND_SEARCH, 32'sd4);
        drain_results();

        // Random phases: clear, fill, then search, with stray words mixed in.
        items    = 0;
        phase_no = 0;
        while (items < RANDOM_ITEMS) begin
            if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
                send_item(KIND_CLEAR, 32'($urandom()));
                items++;
            end
            // The first phase overfills the table so that loads get dropped.
            if (phase_no == 0) begin
                n_loads = STSB_MAX_ENTRIES + 3;
            end
            else if ($urandom_range(0, 19) == 0) begin
                n_loads = $urandom_range(120, 132);
            end
            else begin
                n_loads = $urandom_range(0, 24);
            end
            style = $urandom_range(0, 2);
            for (int i = 0; i < n_loads; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(KIND_UNUSED, 32'($urandom()));
                end
                send_item(KIND_LOAD, load_value(style));
                items++;
            end
            n_searches = $urandom_range(1, 16);
            for (int i = 0; i < n_searches; i++) begin
                case ($urandom_range(0, 24))
                    0: send_item(KIND_UNUSED, 32'($urandom()));
                    1: send_item(KIND_LOAD, load_value(style));
                    2: send_item(KIND_CLEAR, 32'($urandom()));
                    default:
                    begin
                    end
                endcase
                send_item(KIND_SEARCH, search_key());
                items++;
            end
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
            phase_no++;
        end

        // Let every answer arrive, then watch for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("sorted_table_binary_search test passed");
        end
        else begin
            $display("sorted_table_binary_search test failed");
        end
        $finish;
    end

endmodule
